// ===== src/tgvc_pkg.sv =====
`default_nettype none

package tgvc_pkg;

  typedef enum logic [1:0] {
    KIND_SINGLE = 2'd0,
    KIND_DOUBLE = 2'd1,
    KIND_LSTART = 2'd2,
    KIND_LEND   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_SINGLE_CLICK_MAX = 3'd0,
    REG_DOUBLE_WINDOW    = 3'd1,
    REG_LONG_PRESS_MIN   = 3'd2,
    REG_REPEAT_INTERVAL  = 3'd3,
    REG_REPEAT_STEP      = 3'd4,
    REG_VOLUME_MIN       = 3'd5,
    REG_VOLUME_MAX       = 3'd6
  } reg_idx_t;

  localparam logic [11:0] BTN_Y      = 12'd600;
  localparam logic [11:0] BTN_UP_X   = 12'd20;
  localparam logic [11:0] BTN_CHAT_X = 12'd40;
  localparam logic [11:0] BTN_DOWN_X = 12'd60;
  localparam logic [6:0]  CLICK_STEP = 7'd10;
  localparam logic [7:0]  TALLY_MAX  = 8'd255;

  localparam logic [31:0] RST_SINGLE_CLICK_MAX = 32'd300000;
  localparam logic [31:0] RST_DOUBLE_WINDOW    = 32'd400000;
  localparam logic [31:0] RST_LONG_PRESS_MIN   = 32'd800000;
  localparam logic [31:0] RST_REPEAT_INTERVAL  = 32'd200000;
  localparam logic [6:0]  RST_REPEAT_STEP      = 7'd5;
  localparam logic [6:0]  RST_VOLUME_MIN       = 7'd0;
  localparam logic [6:0]  RST_VOLUME_MAX       = 7'd100;

  typedef struct packed {
    logic [3:0]  touch_count;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [31:0] time_us;
    logic [6:0]  current_volume;
  } in_t;

  typedef struct packed {
    logic        event_valid;
    kind_t       event_kind;
    logic [11:0] event_x;
    logic [11:0] event_y;
    logic        chat_toggle;
    logic        volume_write;
    logic [6:0]  volume_value;
  } out_t;

endpackage

`default_nettype wire

// ===== src/touch_gesture_volume_control.sv =====
// Touch gesture classifier with button-zone volume control. One poll sample is
// taken per clock on the in_* channel unless in_stall is high, and gives exactly
// one result beat on the out_* channel: the sample is held in the sample
// register, then passes through the gesture logic into the result register.
// Samples may arrive back to back; the rate is one per cycle while out_stall is
// low, set by the single pass from sample register to result register. in_stall
// rises only while the sample register is full and the result register is full
// and stalled. Write cfg_* only while no sample is in flight.
`default_nettype none

module touch_gesture_volume_control (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire tgvc_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output tgvc_pkg::out_t     out_data,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [31:0]   cfg_data
);

  // configuration
  logic [31:0] single_click_max_us;
  logic [31:0] dbl_click_gap_us;
  logic [31:0] long_press_min_us;
  logic [31:0] repeat_interval_us;
  logic [6:0]  repeat_step;
  logic [6:0]  volume_min;
  logic [6:0]  volume_max;

  // gesture state
  logic        touching, touching_next;
  logic [31:0] press_start_time, press_start_time_next;
  logic [31:0] release_time, release_time_next;
  logic [7:0]  click_tally, click_tally_next;
  logic        long_active, long_active_next;
  logic        repeat_active, repeat_active_next;
  logic        repeat_up, repeat_up_next;
  logic [31:0] last_step_time, last_step_time_next;

  // pipeline
  logic           s1_valid;
  tgvc_pkg::in_t  s1_data;
  logic           out_load;
  logic           s1_fire;
  tgvc_pkg::out_t result;

  // combinational working values
  logic        ev;
  tgvc_pkg::kind_t kind;
  logic        chat;
  logic        wr;
  logic        on_button;
  logic [31:0] held_time;
  logic [31:0] idle_time;
  logic [31:0] step_elapsed;
  logic signed [8:0] vol;
  logic signed [8:0] nv;
  logic signed [8:0] vmin_s;
  logic signed [8:0] vmax_s;
  logic signed [8:0] step_s;

  assign out_load = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && out_load;
  assign in_stall = s1_valid && !out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      single_click_max_us <= tgvc_pkg::RST_SINGLE_CLICK_MAX;
      dbl_click_gap_us    <= tgvc_pkg::RST_DOUBLE_WINDOW;
      long_press_min_us   <= tgvc_pkg::RST_LONG_PRESS_MIN;
      repeat_interval_us  <= tgvc_pkg::RST_REPEAT_INTERVAL;
      repeat_step         <= tgvc_pkg::RST_REPEAT_STEP;
      volume_min          <= tgvc_pkg::RST_VOLUME_MIN;
      volume_max          <= tgvc_pkg::RST_VOLUME_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tgvc_pkg::REG_SINGLE_CLICK_MAX: single_click_max_us <= cfg_data;
        tgvc_pkg::REG_DOUBLE_WINDOW:    dbl_click_gap_us    <= cfg_data;
        tgvc_pkg::REG_LONG_PRESS_MIN:   long_press_min_us   <= cfg_data;
        tgvc_pkg::REG_REPEAT_INTERVAL:  repeat_interval_us  <= cfg_data;
        tgvc_pkg::REG_REPEAT_STEP:      repeat_step         <= cfg_data[6:0];
        tgvc_pkg::REG_VOLUME_MIN:       volume_min          <= cfg_data[6:0];
        tgvc_pkg::REG_VOLUME_MAX:       volume_max          <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      touching         <= 1'b0;
      press_start_time <= '0;
      release_time     <= '0;
      click_tally      <= '0;
      long_active      <= 1'b0;
      repeat_active    <= 1'b0;
      repeat_up        <= 1'b0;
      last_step_time   <= '0;
    end else if (s1_fire) begin
      touching         <= touching_next;
      press_start_time <= press_start_time_next;
      release_time     <= release_time_next;
      click_tally      <= click_tally_next;
      long_active      <= long_active_next;
      repeat_active    <= repeat_active_next;
      repeat_up        <= repeat_up_next;
      last_step_time   <= last_step_time_next;
    end
  end

  always_comb begin
    touching_next         = touching;
    press_start_time_next = press_start_time;
    release_time_next     = release_time;
    click_tally_next      = click_tally;
    long_active_next      = long_active;
    repeat_active_next    = repeat_active;
    repeat_up_next        = repeat_up;
    last_step_time_next   = last_step_time;
    ev   = 1'b0;
    kind = tgvc_pkg::KIND_SINGLE;
    chat = 1'b0;
    wr   = 1'b0;
    held_time = s1_data.time_us - press_start_time;
    idle_time = s1_data.time_us - release_time;
    vol    = {2'b00, s1_data.current_volume};
    vmin_s = {2'b00, volume_min};
    vmax_s = {2'b00, volume_max};
    step_s = {2'b00, repeat_step};
    nv     = '0;

    // press / hold / release / idle classification
    if (s1_data.touch_count != 4'd0 && !touching) begin
      touching_next         = 1'b1;
      press_start_time_next = s1_data.time_us;
      long_active_next      = 1'b0;
    end else if (s1_data.touch_count != 4'd0) begin
      if (!long_active && held_time >= long_press_min_us) begin
        ev               = 1'b1;
        kind             = tgvc_pkg::KIND_LSTART;
        long_active_next = 1'b1;
      end
    end else if (touching) begin
      touching_next     = 1'b0;
      release_time_next = s1_data.time_us;
      if (long_active) begin
        ev   = 1'b1;
        kind = tgvc_pkg::KIND_LEND;
      end else if (held_time <= single_click_max_us) begin
        if (click_tally != tgvc_pkg::TALLY_MAX) begin
          click_tally_next = click_tally + 8'd1;
        end
      end
    end else begin
      if (click_tally != 8'd0 && idle_time >= dbl_click_gap_us) begin
        if (click_tally == 8'd2) begin
          ev   = 1'b1;
          kind = tgvc_pkg::KIND_DOUBLE;
        end else if (click_tally == 8'd1) begin
          ev   = 1'b1;
          kind = tgvc_pkg::KIND_SINGLE;
        end
        // drop triple and longer tallies silently
        click_tally_next = 8'd0;
      end
    end

    on_button = (s1_data.pos_y == tgvc_pkg::BTN_Y) &&
                (s1_data.pos_x == tgvc_pkg::BTN_UP_X ||
                 s1_data.pos_x == tgvc_pkg::BTN_CHAT_X ||
                 s1_data.pos_x == tgvc_pkg::BTN_DOWN_X);

    if (ev && on_button) begin
      case (kind)
        tgvc_pkg::KIND_SINGLE: begin
          if (s1_data.pos_x == tgvc_pkg::BTN_CHAT_X) begin
            chat = 1'b1;
          end else if (s1_data.pos_x == tgvc_pkg::BTN_UP_X) begin
            nv  = vol + $signed({2'b00, tgvc_pkg::CLICK_STEP});
            vol = (nv >= vmax_s) ? vmax_s : nv;
            wr  = 1'b1;
          end else begin
            nv  = vol - $signed({2'b00, tgvc_pkg::CLICK_STEP});
            vol = (nv <= vmin_s) ? vmin_s : nv;
            wr  = 1'b1;
          end
        end
        tgvc_pkg::KIND_LSTART: begin
          if (s1_data.pos_x != tgvc_pkg::BTN_CHAT_X) begin
            repeat_active_next  = 1'b1;
            repeat_up_next      = (s1_data.pos_x == tgvc_pkg::BTN_UP_X);
            last_step_time_next = s1_data.time_us;
          end
        end
        tgvc_pkg::KIND_LEND: begin
          if (s1_data.pos_x != tgvc_pkg::BTN_CHAT_X) begin
            repeat_active_next  = 1'b0;
            repeat_up_next      = 1'b0;
            last_step_time_next = '0;
          end
        end
        default: ;
      endcase
    end

    // auto-repeat works from the click-adjusted volume
    step_elapsed = s1_data.time_us - last_step_time_next;
    if (repeat_active_next && step_elapsed >= repeat_interval_us) begin
      nv = repeat_up_next ? (vol + step_s) : (vol - step_s);
      if (nv > vmax_s) begin
        nv = vmax_s;
      end
      if (nv < vmin_s) begin
        nv = vmin_s;
      end
      if (nv != vol) begin
        vol                 = nv;
        wr                  = 1'b1;
        last_step_time_next = s1_data.time_us;
      end else begin
        repeat_active_next = 1'b0;
        repeat_up_next     = 1'b0;
      end
    end

    result.event_valid  = ev;
    result.event_kind   = ev ? kind : tgvc_pkg::KIND_SINGLE;
    result.event_x      = ev ? s1_data.pos_x : 12'd0;
    result.event_y      = ev ? s1_data.pos_y : 12'd0;
    result.chat_toggle  = chat;
    result.volume_write = wr;
    result.volume_value = wr ? vol[6:0] : 7'd0;
  end

endmodule

`default_nettype wire

// ===== src/tgvc_checker.sv =====
`default_nettype none

module tgvc_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire tgvc_pkg::out_t out_data
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_no_event_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.event_valid |->
      out_data.event_kind == tgvc_pkg::KIND_SINGLE &&
      out_data.event_x == 12'd0 && out_data.event_y == 12'd0)
    else $error("event fields set without an event");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.volume_write |-> out_data.volume_value == 7'd0)
    else $error("volume value set without a write");

  // a running auto-repeat may still write volume on the same beat
  a_chat_button: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.chat_toggle |->
      out_data.event_valid && out_data.event_kind == tgvc_pkg::KIND_SINGLE &&
      out_data.event_x == tgvc_pkg::BTN_CHAT_X && out_data.event_y == tgvc_pkg::BTN_Y)
    else $error("chat toggle without a single click on the chat button");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat valid right after reset");

endmodule

bind touch_gesture_volume_control tgvc_checker u_tgvc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
